>>> hw/rtl/tcc_pkg.sv
// Shared types and constants for the text console cursor/scroll block.
// No dependencies; every other file of the block but tcc_ram refers to it by scoped names.
`timescale 1ns / 1ps

package tcc_pkg;

  localparam int CHAR_W   = 8;
  localparam int COLOR_W  = 8;
  localparam int CELL_W   = CHAR_W + COLOR_W;
  localparam int ROW_FW   = 5;
  localparam int COL_FW   = 7;
  localparam int CFG_DW   = 32;
  localparam int CFG_AW   = 3;

  localparam logic [CHAR_W-1:0]  CODE_CR        = 8'd13;
  localparam logic [CHAR_W-1:0]  CODE_LF        = 8'd10;
  localparam logic [CHAR_W-1:0]  CODE_SPACE     = 8'd32;
  localparam logic [COLOR_W-1:0] TEXT_COLOR_RST = 8'h07;

  // Register select is paddr[2]; register 0 is text_color.
  localparam logic REG_TEXT_COLOR = 1'b0;

  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic accept;     // input transaction taken this cycle
    logic clear_wr;   // post-reset clearing sweep
    logic copy_rd;    // scroll copy, read side
    logic fill_wr;    // blank the bottom row
    logic lookup_rd;  // read the addressed cell
    logic out_load;   // load the result register
  } tcc_cmd_t;

  typedef struct packed {
    logic scroll_req;
    logic clear_last;
    logic copy_last;
    logic fill_last;
    logic out_free;
  } tcc_status_t;

endpackage

>>> hw/rtl/tcc_in_if.sv
// Input channel of the text console: valid/ready plus one item.
// Depends on tcc_pkg for field widths.
`timescale 1ns / 1ps

interface tcc_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [tcc_pkg::CHAR_W-1:0]   char_code;
  logic [tcc_pkg::ROW_FW-1:0]   read_row;
  logic [tcc_pkg::COL_FW-1:0]   read_col;

  modport source (output valid, mode, char_code, read_row, read_col, input ready);
  modport sink   (input valid, mode, char_code, read_row, read_col, output ready);
endinterface

>>> hw/rtl/tcc_out_if.sv
// Result channel of the text console: valid/ready plus one result.
// Depends on tcc_pkg for field widths.
`timescale 1ns / 1ps

interface tcc_out_if;
  logic                         valid;
  logic                         ready;
  logic [tcc_pkg::CHAR_W-1:0]   cell_char;
  logic [tcc_pkg::COLOR_W-1:0]  cell_color;
  logic [tcc_pkg::ROW_FW-1:0]   cursor_row_out;
  logic [tcc_pkg::COL_FW-1:0]   cursor_col_out;

  modport source (output valid, cell_char, cell_color, cursor_row_out, cursor_col_out,
                  input ready);
  modport sink   (input valid, cell_char, cell_color, cursor_row_out, cursor_col_out,
                  output ready);
endinterface

>>> hw/rtl/tcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/tcc_ctrl.sv
// Controller state machine of the text console: sequences clearing, scroll
// copy/fill, cell lookup and result hand-off. Depends on tcc_pkg.
`timescale 1ns / 1ps

module tcc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tcc_pkg::tcc_status_t status,
  output tcc_pkg::tcc_cmd_t    cmd
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_COPY   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FILL   = 3'd4;
  localparam logic [2:0] ST_LOOKUP = 3'd5;
  localparam logic [2:0] ST_DATA   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) state_nxt = status.scroll_req ? ST_COPY : ST_LOOKUP;
      end
      ST_COPY: begin
        cmd.copy_rd = 1'b1;
        if (status.copy_last) state_nxt = ST_DRAIN;
      end
      // The last copied cell is written back while nothing else uses the port.
      ST_DRAIN: begin
        state_nxt = ST_FILL;
      end
      ST_FILL: begin
        cmd.fill_wr = 1'b1;
        if (status.fill_last) state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        cmd.lookup_rd = 1'b1;
        state_nxt     = ST_DATA;
      end
      ST_DATA: begin
        cmd.out_load = status.out_free;
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hw/rtl/tcc_datapath.sv
// Datapath of the text console: cursor, sweep counter, cell store and the
// result register. Depends on tcc_pkg and tcc_ram.
`timescale 1ns / 1ps

module tcc_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tcc_pkg::tcc_cmd_t              cmd,
  output tcc_pkg::tcc_status_t           status,
  input  logic [tcc_pkg::COLOR_W-1:0]    text_color,
  input  logic                           in_mode,
  input  logic [tcc_pkg::CHAR_W-1:0]     in_char_code,
  input  logic [tcc_pkg::ROW_FW-1:0]     in_read_row,
  input  logic [tcc_pkg::COL_FW-1:0]     in_read_col,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tcc_pkg::CHAR_W-1:0]     out_cell_char,
  output logic [tcc_pkg::COLOR_W-1:0]    out_cell_color,
  output logic [tcc_pkg::ROW_FW-1:0]     out_cursor_row,
  output logic [tcc_pkg::COL_FW-1:0]     out_cursor_col
);

  localparam int CELLS      = ROWS * COLUMNS;
  localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;
  localparam int AW         = $clog2(CELLS);
  localparam int RW         = $clog2(ROWS);
  localparam int CW         = $clog2(COLUMNS);
  localparam int CELL_W     = tcc_pkg::CELL_W;

  localparam logic [AW-1:0] COLS_A      = AW'(COLUMNS);
  localparam logic [AW-1:0] BOTTOM_BASE = AW'(COPY_CELLS);
  localparam logic [AW-1:0] CLEAR_END   = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_END    = AW'(COPY_CELLS - 1);
  localparam logic [AW-1:0] FILL_END    = AW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW    = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL    = CW'(COLUMNS - 1);

  logic [RW-1:0]     cur_row_r, cur_row_nxt;
  logic [CW-1:0]     cur_col_r, cur_col_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic              wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]     wr_addr_r, wr_addr_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic              in_range_r, in_range_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CELL_W-1:0] out_cell_r, out_cell_nxt;
  logic [RW-1:0]     out_row_r, out_row_nxt;
  logic [CW-1:0]     out_col_r, out_col_nxt;

  logic              is_cr, is_lf, printable, at_last_col, at_last_row, newline;
  logic              put_item, print_wr, sweep_step, sweep_last;
  logic [AW-1:0]     cur_idx, read_idx;
  logic              read_ok;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  assign is_cr       = (in_char_code == tcc_pkg::CODE_CR);
  assign is_lf       = (in_char_code == tcc_pkg::CODE_LF);
  assign printable   = !is_cr && !is_lf;
  assign at_last_col = (cur_col_r == LAST_COL);
  assign at_last_row = (cur_row_r == LAST_ROW);
  assign newline     = is_lf || (printable && at_last_col);
  assign put_item    = cmd.accept && (in_mode == tcc_pkg::MODE_PUT);
  assign print_wr    = put_item && printable;

  assign cur_idx  = AW'(cur_row_r) * COLS_A + AW'(cur_col_r);
  assign read_idx = AW'(in_read_row) * COLS_A + AW'(in_read_col);
  assign read_ok  = (32'(in_read_row) < 32'(ROWS)) && (32'(in_read_col) < 32'(COLUMNS));

  assign status.scroll_req = (in_mode == tcc_pkg::MODE_PUT) && newline && at_last_row;
  assign status.clear_last = (cnt_r == CLEAR_END);
  assign status.copy_last  = (cnt_r == COPY_END);
  assign status.fill_last  = (cnt_r == FILL_END);
  assign status.out_free   = !out_valid_r || out_ready;

  assign sweep_step = cmd.clear_wr || cmd.copy_rd || cmd.fill_wr;
  assign sweep_last = (cmd.clear_wr && status.clear_last) ||
                      (cmd.copy_rd && status.copy_last) ||
                      (cmd.fill_wr && status.fill_last);

  always_comb begin
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    if (put_item) begin
      if (is_cr) begin
        cur_col_nxt = '0;
      end else if (newline) begin
        cur_col_nxt = '0;
        if (!at_last_row) cur_row_nxt = cur_row_r + RW'(1);
      end else begin
        cur_col_nxt = cur_col_r + CW'(1);
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (sweep_last) begin
      cnt_nxt = '0;
    end else if (sweep_step) begin
      cnt_nxt = cnt_r + AW'(1);
    end
    // Copy is pipelined: a read of row r+1 now, its write to row r next cycle.
    wr_pend_nxt = cmd.copy_rd;
    wr_addr_nxt = cnt_r;
    addr_nxt     = addr_r;
    in_range_nxt = in_range_r;
    if (cmd.accept) begin
      addr_nxt     = (in_mode == tcc_pkg::MODE_PUT) ? cur_idx : read_idx;
      in_range_nxt = (in_mode == tcc_pkg::MODE_PUT) || read_ok;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r;
    ram_wdata = '0;
    if (wr_pend_r) begin
      ram_we    = 1'b1;
      ram_waddr = wr_addr_r;
      ram_wdata = ram_rdata;
    end else if (cmd.fill_wr) begin
      ram_we    = 1'b1;
      ram_waddr = BOTTOM_BASE + cnt_r;
      ram_wdata = {tcc_pkg::CODE_SPACE, text_color};
    end else if (cmd.clear_wr) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_r;
      ram_wdata = '0;
    end else if (print_wr) begin
      ram_we    = 1'b1;
      ram_waddr = cur_idx;
      ram_wdata = {in_char_code, text_color};
    end
    ram_re    = cmd.copy_rd || cmd.lookup_rd;
    ram_raddr = cmd.copy_rd ? (cnt_r + COLS_A) : addr_r;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_cell_nxt  = out_cell_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_cell_nxt  = in_range_r ? ram_rdata : '0;
      out_row_nxt   = cur_row_r;
      out_col_nxt   = cur_col_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  tcc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      cnt_r       <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      cnt_r       <= cnt_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r  <= wr_addr_nxt;
    addr_r     <= addr_nxt;
    in_range_r <= in_range_nxt;
    out_cell_r <= out_cell_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_cell_char  = out_cell_r[CELL_W-1 -: tcc_pkg::CHAR_W];
  assign out_cell_color = out_cell_r[tcc_pkg::COLOR_W-1:0];
  assign out_cursor_row = tcc_pkg::ROW_FW'(out_row_r);
  assign out_cursor_col = tcc_pkg::COL_FW'(out_col_r);

endmodule

>>> hw/rtl/text_console_cursor_scroll.sv
// Teletype text console: a ROWS x COLUMNS store of character/color cells with a
// cursor, written one byte per transaction; carriage return, line feed, wrap
// and scroll-up are handled in hardware. Every transaction returns one result.
// Timing is set by the cell memory, one write and one read port with registered
// read: a plain character, carriage return, line feed or cell read passes through
// accept, memory read and result load, the load waiting while the output register
// holds a result not yet taken. A step that scrolls adds a copy of the lower rows
// one row up, a drain state that finishes the copy pipeline and a blanking of the
// bottom row. After reset the block first clears the memory, one cell per cycle,
// and takes no input transaction until that is done; configuration writes are
// always accepted. A result waiting in the output register does not stop the next
// transaction from being accepted.
// Depends on tcc_pkg, tcc_in_if, tcc_out_if, tcc_ctrl and tcc_datapath.
`timescale 1ns / 1ps

module text_console_cursor_scroll #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                         clk,
  input  logic                         rst_n,
  tcc_in_if.sink                       in_chan,
  tcc_out_if.source                    out_chan,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [tcc_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [tcc_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [tcc_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);

  logic [tcc_pkg::COLOR_W-1:0] text_color_r, text_color_nxt;
  logic                        cfg_wr;
  logic                        sel_color;
  tcc_pkg::tcc_cmd_t           cmd;
  tcc_pkg::tcc_status_t        status;

  assign cfg_pready = 1'b1;
  assign sel_color  = (cfg_paddr[2] == tcc_pkg::REG_TEXT_COLOR);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && sel_color;
  assign cfg_prdata = sel_color ? tcc_pkg::CFG_DW'(text_color_r) : '0;

  always_comb begin
    text_color_nxt = text_color_r;
    if (cfg_wr) text_color_nxt = cfg_pwdata[tcc_pkg::COLOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= tcc_pkg::TEXT_COLOR_RST;
    end else begin
      text_color_r <= text_color_nxt;
    end
  end

  tcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .status   (status),
    .cmd      (cmd)
  );

  tcc_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .text_color     (text_color_r),
    .in_mode        (in_chan.mode),
    .in_char_code   (in_chan.char_code),
    .in_read_row    (in_chan.read_row),
    .in_read_col    (in_chan.read_col),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_cell_char  (out_chan.cell_char),
    .out_cell_color (out_chan.cell_color),
    .out_cursor_row (out_chan.cursor_row_out),
    .out_cursor_col (out_chan.cursor_col_out)
  );

endmodule
